// ----- hw/rtl/pfa_pkg.sv -----
// Shared types and constants of the paged frame allocator.
package pfa_pkg;

    localparam int NUM_FRAMES       = 64;
    localparam int MAX_PROCESSES    = 16;
    localparam int MAX_FRAMES_PER_P = 16;

    localparam int FRAME_W = $clog2(NUM_FRAMES);
    localparam int PID_W   = $clog2(MAX_PROCESSES);
    localparam int SLOT_W  = $clog2(MAX_FRAMES_PER_P);
    localparam int LIST_D  = MAX_PROCESSES * MAX_FRAMES_PER_P;
    localparam int LIST_AW = PID_W + SLOT_W;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NOFREE   = 3'd1;
    localparam logic [2:0] ST_TOOMANY  = 3'd2;
    localparam logic [2:0] ST_BUSY     = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic REG_FRAME_SIZE   = 1'b0;
    localparam logic REG_TOTAL_FRAMES = 1'b1;

    typedef struct packed {
        logic        opcode;
        logic [3:0]  process_id;
        logic [15:0] size_kb;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  process_echo;
        logic [5:0]  frame_index;
        logic        frame_valid;
        logic [9:0]  fragmentation_kb;
        logic        last;
        logic [6:0]  free_frames;
        logic [13:0] total_fragmentation_kb;
    } t_res;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_CHECK,
        S_SCAN,
        S_FREE_RD,
        S_FREE_WR,
        S_FREE_DONE,
        S_RECOUNT
    } t_state;

endpackage

// ----- hw/rtl/paged_frame_allocator.sv -----
// Paged frame allocator top level: first-free bitmap allocation under a sequencer.
//
//  channel   | handshake                     | word
//  ----------+-------------------------------+----------------------
//  request   | start & !busy                 | i_cmd   (t_req)
//  result    | o_result_valid, one cycle     | o_result (t_res)
//  config    | psel & penable & pwrite       | pwdata, paddr[2]
//
//  Allocate: repeated frame-size addition (ceiling division, cut off once more
//  than 16 frames are needed), a check state, then one bitmap frame per cycle
//  up to the highest frame taken. Free: a list RAM read and a release step per
//  frame held, then a closing step. Busy-slot and not-found rejections are
//  decided in the idle state; too-many and no-free rejections end at the check state.
//  A total_frames write in the idle state starts a recount of the usable frames, one per cycle.
//  Reset clears bitmap and slot flags at once; busy is low after reset.
module paged_frame_allocator (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  pfa_pkg::t_req i_cmd,
    output logic          o_result_valid,
    output pfa_pkg::t_res o_result,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    import pfa_pkg::*;

    t_state r_state, n_state;

    logic [10:0] r_fsize;
    logic [6:0]  r_tframes;
    logic [NUM_FRAMES-1:0]    r_used, n_used;
    logic [MAX_PROCESSES-1:0] r_live, n_live;
    logic [4:0]  r_slot_cnt  [MAX_PROCESSES];
    logic [9:0]  r_slot_frag [MAX_PROCESSES];
    logic [6:0]  r_free, n_free;
    logic [13:0] r_fsum, n_fsum;

    t_req        r_req;
    logic [14:0] r_acc, n_acc;
    logic [4:0]  r_need, n_need;
    logic [4:0]  r_got, n_got;
    logic [6:0]  r_idx, n_idx;
    logic [9:0]  r_frag, n_frag;

    logic        r_out_valid, n_out_valid;
    t_res        r_out, n_out;

    logic        cfg_wr;
    logic        accept;
    logic [10:0] fs_eff;
    logic [6:0]  lim;
    logic        slot_wr;
    logic        ram_we;
    logic [LIST_AW-1:0] ram_waddr, ram_raddr;
    logic [FRAME_W-1:0] ram_rdata;
    logic [FRAME_W-1:0] scan_f;
    logic [4:0]  cur_cnt;
    logic [9:0]  cur_frag;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign accept = start && (r_state == S_IDLE);
    assign busy   = (r_state != S_IDLE);

    assign fs_eff = (r_fsize == 11'd0) ? 11'd1 :
                    (r_fsize > 11'd1024) ? 11'd1024 : r_fsize;
    assign lim    = (r_tframes > 7'(NUM_FRAMES)) ? 7'(NUM_FRAMES) : r_tframes;
    assign scan_f = r_idx[FRAME_W-1:0];
    assign cur_cnt  = r_slot_cnt[r_req.process_id];
    assign cur_frag = r_slot_frag[r_req.process_id];

    // register read back
    always_comb begin
        prdata = 32'd0;
        if (paddr[2] == REG_TOTAL_FRAMES) begin
            prdata = {25'd0, r_tframes};
        end else begin
            prdata = {21'd0, r_fsize};
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (cfg_wr && paddr[2] == REG_TOTAL_FRAMES) begin
                    n_state = S_RECOUNT;
                end else if (accept) begin
                    if (i_cmd.opcode == OP_FREE) begin
                        n_state = r_live[i_cmd.process_id] ? S_FREE_RD : S_IDLE;
                    end else begin
                        n_state = r_live[i_cmd.process_id] ? S_IDLE : S_DIV;
                    end
                end
            end
            S_DIV: begin
                if ({1'b0, r_acc} >= r_req.size_kb || r_need == 5'd17) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (r_need > 5'(MAX_FRAMES_PER_P) || {2'b0, r_need} > r_free
                    || r_need == 5'd0) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (!r_used[scan_f] && r_got + 5'd1 == r_need) begin
                    n_state = S_IDLE;
                end
            end
            S_FREE_RD: begin
                n_state = (r_got == cur_cnt) ? S_FREE_DONE : S_FREE_WR;
            end
            S_FREE_WR:   n_state = S_FREE_RD;
            S_FREE_DONE: n_state = S_IDLE;
            S_RECOUNT: begin
                if (r_idx + 7'd1 >= lim) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and result word
    always_comb begin
        n_used = r_used;
        n_live = r_live;
        n_free = r_free;
        n_fsum = r_fsum;
        n_acc  = r_acc;
        n_need = r_need;
        n_got  = r_got;
        n_idx  = r_idx;
        n_frag = r_frag;
        slot_wr = 1'b0;
        ram_we  = 1'b0;
        ram_waddr = {r_req.process_id, r_got[SLOT_W-1:0]};
        ram_raddr = {r_req.process_id, r_got[SLOT_W-1:0]};
        n_out_valid = 1'b0;
        n_out = r_out;
        n_out.process_echo = r_req.process_id;
        n_out.frame_index = '0;
        n_out.frame_valid = 1'b0;
        n_out.fragmentation_kb = '0;
        n_out.last = 1'b1;
        n_out.status = ST_OK;
        case (r_state)
            S_IDLE: begin
                n_acc  = '0;
                n_need = '0;
                n_got  = '0;
                n_idx  = '0;
                n_out.process_echo = i_cmd.process_id;
                if (cfg_wr && paddr[2] == REG_TOTAL_FRAMES) begin
                    n_free = '0;
                end else if (accept && r_live[i_cmd.process_id]
                             == (i_cmd.opcode == OP_ALLOC)) begin
                    // reject: busy slot on allocate, dead slot on free
                    n_out_valid = 1'b1;
                    n_out.status = (i_cmd.opcode == OP_FREE) ? ST_NOTFOUND : ST_BUSY;
                end
            end
            S_DIV: begin
                if (!({1'b0, r_acc} >= r_req.size_kb || r_need == 5'd17)) begin
                    n_acc  = r_acc + {4'd0, fs_eff};
                    n_need = r_need + 5'd1;
                end
            end
            S_CHECK: begin
                n_frag = 10'(16'(r_acc) - r_req.size_kb);
                if (r_need > 5'(MAX_FRAMES_PER_P)) begin
                    n_out_valid = 1'b1;
                    n_out.status = ST_TOOMANY;
                end else if ({2'b0, r_need} > r_free) begin
                    n_out_valid = 1'b1;
                    n_out.status = ST_NOFREE;
                end else begin
                    // commit the slot; results carry the final totals
                    slot_wr = 1'b1;
                    n_live[r_req.process_id] = 1'b1;
                    n_free = r_free - {2'b0, r_need};
                    n_fsum = r_fsum + {4'd0, n_frag};
                    if (r_need == 5'd0) begin
                        n_out_valid = 1'b1;
                        n_out.fragmentation_kb = n_frag;
                    end
                end
            end
            S_SCAN: begin
                n_idx = r_idx + 7'd1;
                if (!r_used[scan_f]) begin
                    n_used[scan_f] = 1'b1;
                    ram_we = 1'b1;
                    n_got = r_got + 5'd1;
                    n_out_valid = 1'b1;
                    n_out.frame_index = scan_f;
                    n_out.frame_valid = 1'b1;
                    n_out.fragmentation_kb = r_frag;
                    n_out.last = (r_got + 5'd1 == r_need);
                end
            end
            S_FREE_WR: begin
                // release one listed frame
                if (r_used[ram_rdata]) begin
                    n_used[ram_rdata] = 1'b0;
                    if ({1'b0, ram_rdata} < lim) begin
                        n_free = r_free + 7'd1;
                    end
                end
                n_got = r_got + 5'd1;
            end
            S_FREE_DONE: begin
                n_live[r_req.process_id] = 1'b0;
                n_fsum = r_fsum - {4'd0, cur_frag};
                n_out_valid = 1'b1;
                n_out.fragmentation_kb = cur_frag;
            end
            S_RECOUNT: begin
                n_idx = r_idx + 7'd1;
                if (r_idx < lim && !r_used[scan_f]) begin
                    n_free = r_free + 7'd1;
                end
            end
            default: ;
        endcase
        n_out.free_frames = n_free;
        n_out.total_fragmentation_kb = n_fsum;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fsize     <= 11'd4;
            r_tframes   <= 7'd64;
            r_used      <= '0;
            r_live      <= '0;
            r_free      <= 7'(NUM_FRAMES);
            r_fsum      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_live      <= n_live;
            r_free      <= n_free;
            r_fsum      <= n_fsum;
            r_out_valid <= n_out_valid;
            if (cfg_wr && paddr[2] == REG_FRAME_SIZE) begin
                r_fsize <= pwdata[10:0];
            end
            if (cfg_wr && paddr[2] == REG_TOTAL_FRAMES) begin
                r_tframes <= pwdata[6:0];
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_cmd;
        end
        if (slot_wr) begin
            r_slot_cnt[r_req.process_id]  <= r_need;
            r_slot_frag[r_req.process_id] <= n_frag;
        end
        r_acc  <= n_acc;
        r_need <= n_need;
        r_got  <= n_got;
        r_idx  <= n_idx;
        r_frag <= n_frag;
        r_out  <= n_out;
    end

    pfa_ram #(
        .WIDTH (FRAME_W),
        .DEPTH (LIST_D)
    ) u_list (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (scan_f),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;
endmodule

// ----- hw/rtl/pfa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module pfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- hw/rtl/pfa_checker.sv -----
// Port-level checks of the paged frame allocator, bound to the top level.
module pfa_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input logic          o_result_valid,
    input pfa_pkg::t_res o_result,
    input logic          pready
);
    import pfa_pkg::*;

    // a result follows only an accepted word or work in progress
    a_res_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(busy || start))
        else $error("result without request");

    // a frame is handed out only on success
    a_frame_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.frame_valid) |-> o_result.status == ST_OK)
        else $error("frame on rejected request");

    // a rejection is always a single closing result
    a_reject_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.status != ST_OK) |-> o_result.last)
        else $error("rejection not last");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n) pready)
        else $error("pready low");
endmodule

bind paged_frame_allocator pfa_checker u_pfa_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_result_valid (o_result_valid),
    .o_result       (o_result),
    .pready         (pready)
);
